/* rtl/dpb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants of the differential drive balancer
// Field widths, command codes, duty limits and the reciprocal constants that
// turn the fixed divisions into multiplications.
// ----------------------------------------------------------------------------
package dpb_pkg;

   localparam int ACTION_WIDTH  = 3;
   localparam int DEGREE_WIDTH  = 9;
   localparam int COUNT_FIELD_W = 16;
   localparam int DUTY_WIDTH    = 7;
   localparam int WORD_WIDTH    = 16;
   localparam int CSR_IDX_WIDTH = 3;

   // Command codes of the action field.
   localparam logic [ACTION_WIDTH-1:0] ACT_ADJUST     = 3'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_FORWARD    = 3'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_BACKWARD   = 3'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_TURN_LEFT  = 3'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_TURN_RIGHT = 3'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_STOP       = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPEED_TOLERANCE    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CATCH_UP_STEP      = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CRUISE_SPEED       = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PWM_PERIOD         = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_QUARTER_TURN_COUNT = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [WORD_WIDTH-1:0] RST_SPEED_TOLERANCE    = 16'd4;
   localparam logic [DUTY_WIDTH-1:0] RST_CATCH_UP_STEP      = 7'd1;
   localparam logic [DUTY_WIDTH-1:0] RST_CRUISE_SPEED       = 7'd50;
   localparam logic [WORD_WIDTH-1:0] RST_PWM_PERIOD         = 16'd1000;
   localparam logic [WORD_WIDTH-1:0] RST_QUARTER_TURN_COUNT = 16'd1000;

   localparam logic [DUTY_WIDTH-1:0]   FULL_DUTY   = 7'd100;
   localparam logic [DEGREE_WIDTH-1:0] RIGHT_ANGLE = 9'd90;

   // Division by 100 for products below 2**23: floor(x * M / 2**30) is exact.
   localparam int PULSE_PROD_WIDTH = DUTY_WIDTH + WORD_WIDTH;
   localparam int PULSE_SHIFT      = 30;
   localparam int PULSE_RECIP_W    = 24;
   localparam logic [PULSE_RECIP_W-1:0] PULSE_RECIP = 24'd10737419;

   // Division by 90 for products below 2**25: floor(x * M / 2**32) is exact.
   localparam int TURN_PROD_WIDTH = DEGREE_WIDTH + WORD_WIDTH;
   localparam int TURN_SHIFT      = 32;
   localparam int TURN_RECIP_W    = 26;
   localparam logic [TURN_RECIP_W-1:0] TURN_RECIP = 26'd47721859;

   // Per-beat flags that ride along the pipeline.
   typedef struct packed {
      logic left_forward;
      logic right_forward;
      logic turn_start;
      logic command_ok;
      logic clear_counters;
   } dpb_flags_type;

endpackage : dpb_pkg
`default_nettype wire

/* rtl/dpb_pulse_scale.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_pulse_scale: duty percent to PWM compare value
// Two registered steps: duty times period, then division by 100 through an
// exact reciprocal multiplication, low 16 bits kept.
// ----------------------------------------------------------------------------
module dpb_pulse_scale (
   input  wire logic                            clock,
   input  wire logic                            load_prod,
   input  wire logic                            load_result,
   input  wire logic [dpb_pkg::DUTY_WIDTH-1:0]  duty,
   input  wire logic [dpb_pkg::WORD_WIDTH-1:0]  period,
   output logic      [dpb_pkg::WORD_WIDTH-1:0]  pulse_width
);
   import dpb_pkg::*;

   localparam int SCALED_WIDTH = PULSE_PROD_WIDTH + PULSE_RECIP_W;

   logic [PULSE_PROD_WIDTH-1:0] prod_ff;
   logic [PULSE_PROD_WIDTH-1:0] prod_in;
   logic [SCALED_WIDTH-1:0]     scaled;
   logic [WORD_WIDTH-1:0]       pulse_ff;
   logic [WORD_WIDTH-1:0]       pulse_in;

   assign prod_in  = PULSE_PROD_WIDTH'(duty) * PULSE_PROD_WIDTH'(period);
   assign scaled   = SCALED_WIDTH'(prod_ff) * SCALED_WIDTH'(PULSE_RECIP);
   assign pulse_in = scaled[PULSE_SHIFT +: WORD_WIDTH];

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff <= prod_in;
      end
      if (load_result) begin
         pulse_ff <= pulse_in;
      end
   end

   assign pulse_width = pulse_ff;

endmodule : dpb_pulse_scale
`default_nettype wire

/* rtl/differential_drive_pwm_balancer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_pwm_balancer_unit: two-wheel duty keeper and balancer
// Takes drive, turn, stop and adjust commands, keeps both wheel duties and
// direction pins, and returns PWM compare values and turn timer periods.
// ----------------------------------------------------------------------------
//
//   Channel   Ports      Direction   Moves per beat
//   -------   --------   ---------   ----------------------------------------
//   request   req_*      in          one command or adjust tick
//   response  rsp_*      out         pulse widths, direction pins, turn flags
//   control   csr_*      in          one register write, no handshake
//
// Every beat passes through four register stages (request, state update,
// multiply, response); the product and reciprocal steps set that depth.
// A new request beat is accepted every cycle unless the pipeline has filled
// up behind a stalled response; a stalled response holds only the last stage
// while earlier stages keep filling. Synchronous reset empties the pipeline,
// zeroes both duties, sets both wheels forward, loads defaults.
// ----------------------------------------------------------------------------
module differential_drive_pwm_balancer_unit #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [dpb_pkg::ACTION_WIDTH-1:0]   req_action,
   input  wire logic [dpb_pkg::DEGREE_WIDTH-1:0]   req_turn_degrees,
   input  wire logic [dpb_pkg::COUNT_FIELD_W-1:0]  req_left_count,
   input  wire logic [dpb_pkg::COUNT_FIELD_W-1:0]  req_right_count,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [dpb_pkg::WORD_WIDTH-1:0]     rsp_left_pulse_width,
   output logic      [dpb_pkg::WORD_WIDTH-1:0]     rsp_right_pulse_width,
   output logic                                    rsp_left_forward,
   output logic                                    rsp_right_forward,
   output logic      [dpb_pkg::WORD_WIDTH-1:0]     rsp_turn_period,
   output logic                                    rsp_turn_start,
   output logic                                    rsp_command_ok,
   output logic                                    rsp_clear_counters,
   // control port
   input  wire logic                               csr_write,
   input  wire logic [dpb_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [dpb_pkg::WORD_WIDTH-1:0]     csr_data
);
   import dpb_pkg::*;

   // Only the low COUNT_WIDTH bits of each 16-bit encoder field take part in
   // the comparison; a wider parameter simply uses the whole field.
   localparam int CMP_WIDTH  = (COUNT_WIDTH < COUNT_FIELD_W) ? COUNT_WIDTH : COUNT_FIELD_W;
   localparam int DIFF_WIDTH = CMP_WIDTH + 1;
   localparam int TOL_WIDTH  = WORD_WIDTH + 2;
   localparam int TURN_SCALED_W = TURN_PROD_WIDTH + TURN_RECIP_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [WORD_WIDTH-1:0] speed_tolerance_ff,    speed_tolerance_in;
   logic [DUTY_WIDTH-1:0] catch_up_step_ff,      catch_up_step_in;
   logic [DUTY_WIDTH-1:0] cruise_speed_ff,       cruise_speed_in;
   logic [WORD_WIDTH-1:0] pwm_period_ff,         pwm_period_in;
   logic [WORD_WIDTH-1:0] quarter_turn_count_ff, quarter_turn_count_in;

   always_comb begin
      speed_tolerance_in    = speed_tolerance_ff;
      catch_up_step_in      = catch_up_step_ff;
      cruise_speed_in       = cruise_speed_ff;
      pwm_period_in         = pwm_period_ff;
      quarter_turn_count_in = quarter_turn_count_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SPEED_TOLERANCE:    speed_tolerance_in    = csr_data;
            CSR_CATCH_UP_STEP:      catch_up_step_in      = csr_data[DUTY_WIDTH-1:0];
            CSR_CRUISE_SPEED:       cruise_speed_in       = csr_data[DUTY_WIDTH-1:0];
            CSR_PWM_PERIOD:         pwm_period_in         = csr_data;
            CSR_QUARTER_TURN_COUNT: quarter_turn_count_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_tolerance_ff    <= RST_SPEED_TOLERANCE;
         catch_up_step_ff      <= RST_CATCH_UP_STEP;
         cruise_speed_ff       <= RST_CRUISE_SPEED;
         pwm_period_ff         <= RST_PWM_PERIOD;
         quarter_turn_count_ff <= RST_QUARTER_TURN_COUNT;
      end else begin
         speed_tolerance_ff    <= speed_tolerance_in;
         catch_up_step_ff      <= catch_up_step_in;
         cruise_speed_ff       <= cruise_speed_in;
         pwm_period_ff         <= pwm_period_in;
         quarter_turn_count_ff <= quarter_turn_count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control. A stage loads when the stage before holds a
   // beat and this stage is empty or hands its own beat on.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic s1_ready, s2_ready, s3_ready, s4_ready;
   logic load_s1, load_s2, load_s3, load_s4;

   assign s4_ready = !s4_valid_ff || !rsp_stall;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign load_s1 = req_valid && s1_ready;
   assign load_s2 = s1_valid_ff && s2_ready;
   assign load_s3 = s2_valid_ff && s3_ready;
   assign load_s4 = s3_valid_ff && s4_ready;

   assign s1_valid_in = load_s1 || (s1_valid_ff && !load_s2);
   assign s2_valid_in = load_s2 || (s2_valid_ff && !load_s3);
   assign s3_valid_in = load_s3 || (s3_valid_ff && !load_s4);
   assign s4_valid_in = load_s4 || (s4_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   assign req_stall = !s1_ready;

   // ---------------------------------------------------------------------
   // Stage 1: request register.
   // ---------------------------------------------------------------------
   logic [ACTION_WIDTH-1:0]  s1_action_ff;
   logic [DEGREE_WIDTH-1:0]  s1_degrees_ff;
   logic [COUNT_FIELD_W-1:0] s1_left_count_ff;
   logic [COUNT_FIELD_W-1:0] s1_right_count_ff;

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_action_ff      <= req_action;
         s1_degrees_ff     <= req_turn_degrees;
         s1_left_count_ff  <= req_left_count;
         s1_right_count_ff <= req_right_count;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: wheel state update. The duty and direction registers change
   // as the beat moves from stage 1 into stage 2, so the next beat already
   // sees the result of this one.
   // ---------------------------------------------------------------------
   logic [DUTY_WIDTH-1:0] left_duty_ff,  left_duty_in;
   logic [DUTY_WIDTH-1:0] right_duty_ff, right_duty_in;
   logic                  left_dir_ff,   left_dir_in;
   logic                  right_dir_ff,  right_dir_in;

   logic [DUTY_WIDTH-1:0]       cruise_duty;
   logic [DUTY_WIDTH:0]         left_up_sum, right_up_sum;
   logic [DUTY_WIDTH-1:0]       left_up, right_up, left_down, right_down;
   logic [CMP_WIDTH-1:0]        left_cmp, right_cmp;
   logic signed [DIFF_WIDTH-1:0] count_diff;
   logic signed [TOL_WIDTH-1:0]  diff_wide, tol_pos, tol_neg;
   logic                        left_faster, right_faster;
   logic                        angle_ok;
   dpb_flags_type               flags_in;
   logic [TURN_PROD_WIDTH-1:0]  turn_prod_in;

   // Cruise speed saturates at full duty.
   assign cruise_duty = (cruise_speed_ff > FULL_DUTY) ? FULL_DUTY : cruise_speed_ff;

   // Raising a duty clamps at full duty; lowering it stops at zero.
   assign left_up_sum  = {1'b0, left_duty_ff}  + {1'b0, catch_up_step_ff};
   assign right_up_sum = {1'b0, right_duty_ff} + {1'b0, catch_up_step_ff};
   assign left_up   = (left_up_sum  > {1'b0, FULL_DUTY}) ? FULL_DUTY : left_up_sum[DUTY_WIDTH-1:0];
   assign right_up  = (right_up_sum > {1'b0, FULL_DUTY}) ? FULL_DUTY
                                                          : right_up_sum[DUTY_WIDTH-1:0];
   assign left_down  = (catch_up_step_ff >= left_duty_ff)  ? '0 : left_duty_ff - catch_up_step_ff;
   assign right_down = (catch_up_step_ff >= right_duty_ff) ? '0
                                                            : right_duty_ff - catch_up_step_ff;

   // Signed encoder difference against the symmetric tolerance window.
   assign left_cmp   = s1_left_count_ff[CMP_WIDTH-1:0];
   assign right_cmp  = s1_right_count_ff[CMP_WIDTH-1:0];
   assign count_diff = $signed({1'b0, left_cmp}) - $signed({1'b0, right_cmp});
   assign diff_wide  = TOL_WIDTH'(count_diff);
   assign tol_pos    = $signed({2'b00, speed_tolerance_ff});
   assign tol_neg    = -tol_pos;
   assign left_faster  = diff_wide > tol_pos;
   assign right_faster = diff_wide < tol_neg;

   assign angle_ok = (s1_degrees_ff != '0) && (s1_degrees_ff <= RIGHT_ANGLE);

   always_comb begin
      left_duty_in  = left_duty_ff;
      right_duty_in = right_duty_ff;
      left_dir_in   = left_dir_ff;
      right_dir_in  = right_dir_ff;
      flags_in      = '0;
      flags_in.command_ok = 1'b1;
      turn_prod_in  = '0;
      case (s1_action_ff)
         ACT_ADJUST: begin
            flags_in.clear_counters = 1'b1;
            // Nothing is balanced while either wheel is stopped.
            if ((left_duty_ff != '0) && (right_duty_ff != '0)) begin
               if (left_faster) begin
                  left_duty_in  = left_down;
                  right_duty_in = right_up;
               end else if (right_faster) begin
                  left_duty_in  = left_up;
                  right_duty_in = right_down;
               end
            end
         end
         ACT_FORWARD, ACT_BACKWARD: begin
            left_duty_in  = cruise_duty;
            right_duty_in = cruise_duty;
            left_dir_in   = (s1_action_ff == ACT_FORWARD);
            right_dir_in  = (s1_action_ff == ACT_FORWARD);
         end
         ACT_TURN_LEFT, ACT_TURN_RIGHT: begin
            if (angle_ok) begin
               left_duty_in  = cruise_duty;
               right_duty_in = cruise_duty;
               left_dir_in   = (s1_action_ff == ACT_TURN_RIGHT);
               right_dir_in  = (s1_action_ff == ACT_TURN_LEFT);
               flags_in.turn_start = 1'b1;
               turn_prod_in  = TURN_PROD_WIDTH'(s1_degrees_ff)
                             * TURN_PROD_WIDTH'(quarter_turn_count_ff);
            end else begin
               // A bad angle stops both wheels and keeps the directions.
               left_duty_in  = '0;
               right_duty_in = '0;
               flags_in.command_ok = 1'b0;
            end
         end
         ACT_STOP: begin
            left_duty_in  = '0;
            right_duty_in = '0;
         end
         default: ;
      endcase
      flags_in.left_forward  = left_dir_in;
      flags_in.right_forward = right_dir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_duty_ff  <= '0;
         right_duty_ff <= '0;
         left_dir_ff   <= 1'b1;
         right_dir_ff  <= 1'b1;
      end else if (load_s2) begin
         left_duty_ff  <= left_duty_in;
         right_duty_ff <= right_duty_in;
         left_dir_ff   <= left_dir_in;
         right_dir_ff  <= right_dir_in;
      end
   end

   dpb_flags_type              s2_flags_ff;
   logic [TURN_PROD_WIDTH-1:0] s2_turn_prod_ff;

   always_ff @(posedge clock) begin
      if (load_s2) begin
         s2_flags_ff     <= flags_in;
         s2_turn_prod_ff <= turn_prod_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stages 3 and 4: pulse width scaling for both wheels, and the turn
   // period divided by 90 through its reciprocal.
   // ---------------------------------------------------------------------
   dpb_pulse_scale u_left_scale (
      .clock       (clock),
      .load_prod   (load_s3),
      .load_result (load_s4),
      .duty        (left_duty_ff),
      .period      (pwm_period_ff),
      .pulse_width (rsp_left_pulse_width)
   );

   dpb_pulse_scale u_right_scale (
      .clock       (clock),
      .load_prod   (load_s3),
      .load_result (load_s4),
      .duty        (right_duty_ff),
      .period      (pwm_period_ff),
      .pulse_width (rsp_right_pulse_width)
   );

   logic [TURN_SCALED_W-1:0] turn_scaled;
   logic [WORD_WIDTH-1:0]    s3_turn_period_ff, s3_turn_period_in;
   dpb_flags_type            s3_flags_ff;
   logic [WORD_WIDTH-1:0]    s4_turn_period_ff;
   dpb_flags_type            s4_flags_ff;

   assign turn_scaled       = TURN_SCALED_W'(s2_turn_prod_ff) * TURN_SCALED_W'(TURN_RECIP);
   assign s3_turn_period_in = turn_scaled[TURN_SHIFT +: WORD_WIDTH];

   always_ff @(posedge clock) begin
      if (load_s3) begin
         s3_turn_period_ff <= s3_turn_period_in;
         s3_flags_ff       <= s2_flags_ff;
      end
      if (load_s4) begin
         s4_turn_period_ff <= s3_turn_period_ff;
         s4_flags_ff       <= s3_flags_ff;
      end
   end

   assign rsp_valid          = s4_valid_ff;
   assign rsp_turn_period    = s4_turn_period_ff;
   assign rsp_left_forward   = s4_flags_ff.left_forward;
   assign rsp_right_forward  = s4_flags_ff.right_forward;
   assign rsp_turn_start     = s4_flags_ff.turn_start;
   assign rsp_command_ok     = s4_flags_ff.command_ok;
   assign rsp_clear_counters = s4_flags_ff.clear_counters;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // Saturation keeps both duties within full scale.
   assert property (@(posedge clock) disable iff (reset)
      (left_duty_ff <= FULL_DUTY) && (right_duty_ff <= FULL_DUTY))
      else $error("wheel duty above full scale");

   // A turn period only leaves with a started turn, and a started turn is
   // never a failed command or an adjust tick.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_turn_start) |-> (rsp_turn_period == '0))
      else $error("turn period without a started turn");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_turn_start) |-> (rsp_command_ok && !rsp_clear_counters))
      else $error("turn start flagged with failure or counter clear");

   // A beat entering an empty pipeline passes the request, state update and
   // multiply registers and reaches the response register without waiting.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !s1_valid_ff && !s2_valid_ff && !s3_valid_ff
       && !s4_valid_ff) |-> ##4 rsp_valid)
      else $error("response latency off on an empty pipeline");

endmodule : differential_drive_pwm_balancer_unit
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the differential drive PWM balancer unit
// Feeds drive, turn, stop, adjust and unused commands through the request
// channel under random idling and stalls. A behavioral model of the duty and
// direction state predicts every response beat, and the monitor compares
// each response with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
   import dpb_pkg::*;

   // Codes that the block treats as no-operations.
   localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_HI = 3'd7;

   // Four register stages from request to response.
   localparam int PIPE_LATENCY  = 4;
   localparam int DRAIN_CYCLES  = 2 * PIPE_LATENCY;
   // Long receiver hold-off, well past the pipeline depth.
   localparam int HOLD_CYCLES   = 160;
   // Longest run of cycles with no beat on either channel before giving up.
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_BEATS   = 255;
   localparam int IDLE_PERCENT  = 18;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0]  action;
      logic [DEGREE_WIDTH-1:0]  turn_degrees;
      logic [COUNT_FIELD_W-1:0] left_count;
      logic [COUNT_FIELD_W-1:0] right_count;
   } command_beat_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] left_pulse_width;
      logic [WORD_WIDTH-1:0] right_pulse_width;
      logic                  left_forward;
      logic                  right_forward;
      logic [WORD_WIDTH-1:0] turn_period;
      logic                  turn_start;
      logic                  command_ok;
      logic                  clear_counters;
   } wheel_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic [ACTION_WIDTH-1:0]  req_action       = '0;
   logic [DEGREE_WIDTH-1:0]  req_turn_degrees = '0;
   logic [COUNT_FIELD_W-1:0] req_left_count   = '0;
   logic [COUNT_FIELD_W-1:0] req_right_count  = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [WORD_WIDTH-1:0] rsp_left_pulse_width;
   logic [WORD_WIDTH-1:0] rsp_right_pulse_width;
   logic                  rsp_left_forward;
   logic                  rsp_right_forward;
   logic [WORD_WIDTH-1:0] rsp_turn_period;
   logic                  rsp_turn_start;
   logic                  rsp_command_ok;
   logic                  rsp_clear_counters;

   logic                     csr_write = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [WORD_WIDTH-1:0]    csr_data  = '0;

   // Commands waiting to be driven, and responses the model has predicted.
   command_beat_type command_backlog[$];
   wheel_report_type predicted_reports[$];

   int beats_queued  = 0;
   int beats_popped  = 0;
   int reports_seen  = 0;
   int mismatches    = 0;
   int idle_cycles   = 0;
   int hold_count    = 0;

   // Knobs that the stimulus process turns at falling edges; the monitor clears hold_req.
   bit quiet       = 1'b0;
   bit hold_sender = 1'b0;
   bit hold_req    = 1'b0;

   // Shadow of the configuration registers as last written.
   logic [WORD_WIDTH-1:0] cfg_tolerance;
   logic [DUTY_WIDTH-1:0] cfg_step;
   logic [DUTY_WIDTH-1:0] cfg_cruise;
   logic [WORD_WIDTH-1:0] cfg_period;
   logic [WORD_WIDTH-1:0] cfg_quarter_turn;

   // Model copy of the wheel state. Reset leaves both wheels stopped, forward.
   logic [DUTY_WIDTH-1:0] left_duty  = '0;
   logic [DUTY_WIDTH-1:0] right_duty = '0;
   logic                  left_dir   = 1'b1;
   logic                  right_dir  = 1'b1;

   differential_drive_pwm_balancer_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_turn_degrees      (req_turn_degrees),
      .req_left_count        (req_left_count),
      .req_right_count       (req_right_count),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_left_pulse_width  (rsp_left_pulse_width),
      .rsp_right_pulse_width (rsp_right_pulse_width),
      .rsp_left_forward      (rsp_left_forward),
      .rsp_right_forward     (rsp_right_forward),
      .rsp_turn_period       (rsp_turn_period),
      .rsp_turn_start        (rsp_turn_start),
      .rsp_command_ok        (rsp_command_ok),
      .rsp_clear_counters    (rsp_clear_counters),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Duty arithmetic saturates at both ends of the percent range.
   function automatic logic [DUTY_WIDTH-1:0] raise_duty(input logic [DUTY_WIDTH-1:0] duty,
                                                        input logic [DUTY_WIDTH-1:0] step);
      int sum;
      sum = int'(duty) + int'(step);
      return (sum > int'(FULL_DUTY)) ? FULL_DUTY : sum[DUTY_WIDTH-1:0];
   endfunction

   function automatic logic [DUTY_WIDTH-1:0] lower_duty(input logic [DUTY_WIDTH-1:0] duty,
                                                        input logic [DUTY_WIDTH-1:0] step);
      return (step >= duty) ? '0 : duty - step;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] pulse_width_of(input logic [DUTY_WIDTH-1:0] duty);
      longint product;
      product = longint'(duty) * longint'(cfg_period) / 100;
      return product[WORD_WIDTH-1:0];
   endfunction

   // Applies one command to the model state and returns the response it causes.
   function automatic wheel_report_type predict_wheel_report(input command_beat_type cmd);
      wheel_report_type      rep;
      logic [DUTY_WIDTH-1:0] cruise;
      int                    diff;
      int                    tol;
      longint                span;
      rep            = '0;
      rep.command_ok = 1'b1;
      cruise         = (cfg_cruise > FULL_DUTY) ? FULL_DUTY : cfg_cruise;
      case (cmd.action)
         ACT_ADJUST: begin
            rep.clear_counters = 1'b1;
            // A stopped wheel is never balanced.
            if (left_duty != 0 && right_duty != 0) begin
               diff = int'(cmd.left_count) - int'(cmd.right_count);
               tol  = int'(cfg_tolerance);
               if (diff > tol) begin
                  left_duty  = lower_duty(left_duty, cfg_step);
                  right_duty = raise_duty(right_duty, cfg_step);
               end else if (diff < -tol) begin
                  left_duty  = raise_duty(left_duty, cfg_step);
                  right_duty = lower_duty(right_duty, cfg_step);
               end
            end
         end
         ACT_FORWARD, ACT_BACKWARD: begin
            left_duty  = cruise;
            right_duty = cruise;
            left_dir   = (cmd.action == ACT_FORWARD);
            right_dir  = left_dir;
         end
         ACT_TURN_LEFT, ACT_TURN_RIGHT: begin
            if (cmd.turn_degrees == 0 || cmd.turn_degrees > RIGHT_ANGLE) begin
               // A bad angle stops both wheels but leaves the pins alone.
               left_duty      = '0;
               right_duty     = '0;
               rep.command_ok = 1'b0;
            end else begin
               left_duty       = cruise;
               right_duty      = cruise;
               span            = longint'(cmd.turn_degrees) * longint'(cfg_quarter_turn) / 90;
               rep.turn_period = span[WORD_WIDTH-1:0];
               rep.turn_start  = 1'b1;
               left_dir        = (cmd.action == ACT_TURN_RIGHT);
               right_dir       = (cmd.action == ACT_TURN_LEFT);
            end
         end
         ACT_STOP: begin
            left_duty  = '0;
            right_duty = '0;
         end
         default: begin
         end
      endcase
      rep.left_pulse_width  = pulse_width_of(left_duty);
      rep.right_pulse_width = pulse_width_of(right_duty);
      rep.left_forward      = left_dir;
      rep.right_forward     = right_dir;
      return rep;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Driver. A beat sits on the request port until the block takes it; a new
   // beat is loaded only after the previous one was taken or when the port is
   // empty. The sender idles at random unless a quiet phase is running, and
   // holds back entirely while hold_sender is set.
   always @(posedge clock) begin : driver
      command_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            beat.action       = req_action;
            beat.turn_degrees = req_turn_degrees;
            beat.left_count   = req_left_count;
            beat.right_count  = req_right_count;
            predicted_reports.push_back(predict_wheel_report(beat));
         end
         if (!req_valid || !req_stall) begin
            if (command_backlog.size() != 0 && !hold_sender &&
                !(!quiet && $urandom_range(99) < IDLE_PERCENT)) begin
               beat = command_backlog.pop_front();
               beats_popped++;
               req_valid        <= 1'b1;
               req_action       <= beat.action;
               req_turn_degrees <= beat.turn_degrees;
               req_left_count   <= beat.left_count;
               req_right_count  <= beat.right_count;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every response beat is matched against the oldest prediction.
   // The stall line is random outside quiet phases, or held high for a long
   // stretch on request so that the pipeline backs up into the request channel.
   always @(posedge clock) begin : monitor
      wheel_report_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            reports_seen++;
            if (predicted_reports.size() == 0) begin
               $error("response beat arrived with no command outstanding");
               mismatches++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("left_pulse_width", 32'(want.left_pulse_width),
                           32'(rsp_left_pulse_width));
               check_field("right_pulse_width", 32'(want.right_pulse_width),
                           32'(rsp_right_pulse_width));
               check_field("left_forward", 32'(want.left_forward), 32'(rsp_left_forward));
               check_field("right_forward", 32'(want.right_forward), 32'(rsp_right_forward));
               check_field("turn_period", 32'(want.turn_period), 32'(rsp_turn_period));
               check_field("turn_start", 32'(want.turn_start), 32'(rsp_turn_start));
               check_field("command_ok", 32'(want.command_ok), 32'(rsp_command_ok));
               check_field("clear_counters", 32'(want.clear_counters),
                           32'(rsp_clear_counters));
            end
         end
         if (hold_count != 0) begin
            hold_count <= hold_count - 1;
            rsp_stall  <= 1'b1;
         end else if (hold_req) begin
            hold_req   <= 1'b0;
            hold_count <= HOLD_CYCLES;
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Watchdog: too long with no beat on either channel means the block hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("differential_drive_pwm_balancer_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_command(input logic [ACTION_WIDTH-1:0]  action,
                                input logic [DEGREE_WIDTH-1:0]  degrees,
                                input logic [COUNT_FIELD_W-1:0] left_count,
                                input logic [COUNT_FIELD_W-1:0] right_count);
      command_beat_type beat;
      beat.action       = action;
      beat.turn_degrees = degrees;
      beat.left_count   = left_count;
      beat.right_count  = right_count;
      command_backlog.push_back(beat);
      beats_queued++;
   endtask

   // Writes all five registers on consecutive edges; only called while idle.
   task automatic program_registers(input logic [WORD_WIDTH-1:0] tolerance,
                                    input logic [DUTY_WIDTH-1:0] step,
                                    input logic [DUTY_WIDTH-1:0] cruise,
                                    input logic [WORD_WIDTH-1:0] period,
                                    input logic [WORD_WIDTH-1:0] quarter_turn);
      logic [WORD_WIDTH-1:0] values[5];
      logic [CSR_IDX_WIDTH-1:0] indexes[5];
      values  = '{tolerance, WORD_WIDTH'(step), WORD_WIDTH'(cruise), period, quarter_turn};
      indexes = '{CSR_SPEED_TOLERANCE, CSR_CATCH_UP_STEP, CSR_CRUISE_SPEED,
                  CSR_PWM_PERIOD, CSR_QUARTER_TURN_COUNT};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_write <= 1'b1;
         csr_index <= indexes[i];
         csr_data  <= values[i];
      end
      @(posedge clock);
      csr_write        <= 1'b0;
      cfg_tolerance    = tolerance;
      cfg_step         = step;
      cfg_cruise       = cruise;
      cfg_period       = period;
      cfg_quarter_turn = quarter_turn;
   endtask

   // Waits until every queued command has its response, then lets the
   // pipeline settle before anything touches the registers.
   task automatic drain_pipeline();
      wait (reports_seen == beats_queued);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random command mix. Adjust ticks dominate and mostly land right around
   // the tolerance, since that is where the balancing decisions happen; the
   // drive and turn commands keep the duties nonzero so the ticks have work.
   function automatic command_beat_type random_command();
      command_beat_type beat;
      int pick;
      int gap;
      int high_count;
      beat.action       = ACT_ADJUST;
      beat.turn_degrees = DEGREE_WIDTH'($urandom_range(511));
      beat.left_count   = COUNT_FIELD_W'($urandom_range(65535));
      beat.right_count  = COUNT_FIELD_W'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 35) begin
         case ($urandom_range(4))
            0: gap = int'(cfg_tolerance) - 1;
            1: gap = int'(cfg_tolerance);
            2: gap = int'(cfg_tolerance) + 1;
            3: gap = int'(cfg_tolerance) + $urandom_range(50);
            default: gap = $urandom_range(65535);
         endcase
         if (gap < 0) gap = 0;
         if (gap > 65535) gap = 65535;
         high_count = $urandom_range(65535, gap);
         if ($urandom_range(1)) begin
            beat.left_count  = COUNT_FIELD_W'(high_count);
            beat.right_count = COUNT_FIELD_W'(high_count - gap);
         end else begin
            beat.right_count = COUNT_FIELD_W'(high_count);
            beat.left_count  = COUNT_FIELD_W'(high_count - gap);
         end
      end else if (pick < 45) begin
         beat.action = ACT_ADJUST;
      end else if (pick < 57) begin
         beat.action = ACT_FORWARD;
      end else if (pick < 65) begin
         beat.action = ACT_BACKWARD;
      end else if (pick < 86) begin
         beat.action = $urandom_range(1) ? ACT_TURN_LEFT : ACT_TURN_RIGHT;
         case ($urandom_range(19))
            0:       beat.turn_degrees = '0;
            1:       beat.turn_degrees = RIGHT_ANGLE;
            2, 3:    beat.turn_degrees = DEGREE_WIDTH'($urandom_range(511, 91));
            default: beat.turn_degrees = DEGREE_WIDTH'($urandom_range(90, 1));
         endcase
      end else if (pick < 95) begin
         beat.action = ACT_STOP;
      end else begin
         beat.action = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end
      return beat;
   endfunction

   initial begin
      command_beat_type beat;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Register defaults, then the basic moves. The first tick arrives
      // with both wheels stopped and must leave the duties alone.
      program_registers(RST_SPEED_TOLERANCE, RST_CATCH_UP_STEP, RST_CRUISE_SPEED,
                        RST_PWM_PERIOD, RST_QUARTER_TURN_COUNT);
      queue_command(ACT_ADJUST, 9'd0, 16'hFFFF, 16'h0000);
      queue_command(ACT_FORWARD, 9'd0, 16'd0, 16'd0);
      queue_command(ACT_ADJUST, 9'd0, 16'd105, 16'd100);   // just past tolerance
      queue_command(ACT_ADJUST, 9'd0, 16'd100, 16'd104);   // exactly at tolerance
      queue_command(ACT_ADJUST, 9'd0, 16'h0000, 16'hFFFF); // widest negative gap
      queue_command(ACT_BACKWARD, 9'd0, 16'd0, 16'd0);
      queue_command(ACT_TURN_LEFT, 9'd1, 16'd0, 16'd0);
      queue_command(ACT_TURN_RIGHT, RIGHT_ANGLE, 16'd0, 16'd0);
      queue_command(ACT_TURN_LEFT, 9'd0, 16'd0, 16'd0);    // zero angle is rejected
      queue_command(ACT_TURN_RIGHT, 9'd91, 16'd0, 16'd0);  // just beyond a right angle
      queue_command(ACT_FORWARD, 9'd0, 16'd0, 16'd0);
      queue_command(ACT_TURN_LEFT, 9'h1FF, 16'hFFFF, 16'hFFFF);
      queue_command(ACT_STOP, 9'd0, 16'd0, 16'd0);
      queue_command(ACT_ADJUST, 9'h1FF, 16'd500, 16'd0);
      queue_command(ACT_SPARE_LO, 9'h0AA, 16'h5555, 16'hAAAA);
      queue_command(ACT_SPARE_HI, 9'h1FF, 16'hFFFF, 16'hFFFF);
      drain_pipeline();

      // Top of every range: cruise above full duty saturates, a full step
      // moves the whole duty across, and the longest turn fills the timer.
      program_registers(16'd0, FULL_DUTY, 7'd127, 16'hFFFF, 16'hFFFF);
      queue_command(ACT_FORWARD, 9'd0, 16'd0, 16'd0);
      queue_command(ACT_ADJUST, 9'd0, 16'd1, 16'd0);
      queue_command(ACT_ADJUST, 9'd0, 16'd0, 16'd1);
      queue_command(ACT_TURN_RIGHT, RIGHT_ANGLE, 16'd0, 16'd0);
      queue_command(ACT_TURN_LEFT, 9'd45, 16'd0, 16'd0);
      queue_command(ACT_ADJUST, 9'd0, 16'd0, 16'd0);
      drain_pipeline();

      // Bottom of every range: zero cruise, period and turn count.
      program_registers(16'hFFFF, 7'd0, 7'd0, 16'd0, 16'd0);
      queue_command(ACT_FORWARD, 9'd0, 16'd0, 16'd0);
      queue_command(ACT_ADJUST, 9'd0, 16'hFFFF, 16'd0);
      queue_command(ACT_TURN_LEFT, 9'd30, 16'd0, 16'd0);
      drain_pipeline();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_registers(WORD_WIDTH'($urandom_range(8)),
                                 DUTY_WIDTH'($urandom_range(5, 1)),
                                 DUTY_WIDTH'($urandom_range(80, 20)),
                                 WORD_WIDTH'($urandom_range(65535)),
                                 WORD_WIDTH'($urandom_range(65535)));
            1: program_registers(WORD_WIDTH'($urandom_range(3)),
                                 DUTY_WIDTH'($urandom_range(10, 1)),
                                 DUTY_WIDTH'($urandom_range(100, 1)),
                                 RST_PWM_PERIOD, WORD_WIDTH'($urandom_range(65535)));
            2: program_registers(WORD_WIDTH'($urandom_range(30)),
                                 DUTY_WIDTH'($urandom_range(100)), FULL_DUTY,
                                 WORD_WIDTH'($urandom_range(65535)), 16'hFFFF);
            3: program_registers(WORD_WIDTH'($urandom_range(65535)),
                                 DUTY_WIDTH'($urandom_range(3, 1)),
                                 DUTY_WIDTH'($urandom_range(100)),
                                 WORD_WIDTH'($urandom_range(65535)),
                                 WORD_WIDTH'($urandom_range(65535)));
            4: program_registers(16'd0, FULL_DUTY, FULL_DUTY, 16'hFFFF, 16'hFFFF);
            default: program_registers(WORD_WIDTH'($urandom_range(2)), 7'd1, 7'd1,
                                       16'd100, 16'd90);
         endcase
         @(negedge clock);
         quiet = (phase == 2);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            beat = random_command();
            queue_command(beat.action, beat.turn_degrees, beat.left_count, beat.right_count);
         end
         if (phase == 1) begin
            // Receiver sits on its stall while the sender keeps offering.
            hold_req = 1'b1;
         end
         if (phase == 3) begin
            // Midway through, the sender stops until the pipeline runs dry.
            wait (command_backlog.size() < PHASE_BEATS / 2);
            @(negedge clock);
            hold_sender = 1'b1;
            wait (reports_seen == beats_popped);
            @(negedge clock);
            hold_sender = 1'b0;
         end
         drain_pipeline();
         @(negedge clock);
         quiet = 1'b0;
      end

      if (predicted_reports.size() != 0) begin
         $error("%0d predicted responses never arrived", predicted_reports.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("differential_drive_pwm_balancer_unit regression: pass");
      end else begin
         $display("differential_drive_pwm_balancer_unit regression: fail");
      end
      $finish;
   end

endmodule
